[hdl/assert_macros.svh]
// Assertion macros shared by the vector store RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while the synchronous reset is low.
`define VSN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define VSN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/vsn_pkg.sv]
// Types and constants of the vector store with norms.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package vsn_pkg;

  localparam int MAX_LENGTH = 16;
  localparam int IDX_W      = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
  localparam int CFG_W      = 5;
  localparam int IN_IDX_W   = 5;
  localparam int VAL_W      = 16;
  localparam int CMP_W      = (IN_IDX_W > LEN_W) ? IN_IDX_W : LEN_W;
  localparam int MAG_W      = VAL_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + IDX_W;
  localparam int ROOT_W     = (SUM_W + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_W + 1);
  localparam int NORM_W     = 18;

  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(16);

  typedef struct packed {
    logic                    write_enable;
    logic [IN_IDX_W-1:0]     write_index;
    logic signed [VAL_W-1:0] write_value;
    logic [IN_IDX_W-1:0]     read_index;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [NORM_W-1:0]       euclid_norm;
    logic [MAG_W-1:0]        largest_magnitude;
    logic                    write_ignored;
  } out_res_t;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             done;
  } dp_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
  } dp_status_t;

endpackage

[hdl/vsn_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used by the vector store datapath.
`timescale 1ns / 1ps

module vsn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/vsn_ctrl.sv]
// Controller of the vector store: sequences the write, the walk over the
// stored entries, the square root and the result strobe. Uses vsn_pkg.
`timescale 1ns / 1ps

module vsn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vsn_pkg::dp_status_t status,
  output vsn_pkg::dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_WALK   = 7'b0000010,
    ST_DRAIN1 = 7'b0000100,
    ST_DRAIN2 = 7'b0001000,
    ST_SQINIT = 7'b0010000,
    ST_SQRT   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  localparam logic [vsn_pkg::STEP_W-1:0] STEP_LAST = vsn_pkg::STEP_W'(vsn_pkg::ROOT_W - 1);

  state_t                       state_r, state_nxt;
  logic [vsn_pkg::LEN_W-1:0]    idx_cnt_r, idx_cnt_nxt;
  logic [vsn_pkg::STEP_W-1:0]   step_cnt_r, step_cnt_nxt;
  logic [vsn_pkg::LEN_W-1:0]    idx_inc;

  assign idx_inc = vsn_pkg::LEN_W'(idx_cnt_r + 1'b1);

  always_comb begin
    state_nxt     = state_r;
    idx_cnt_nxt   = idx_cnt_r;
    step_cnt_nxt  = step_cnt_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        idx_cnt_nxt = '0;
        if (start) begin
          cmd.load = 1'b1;
          if (status.len == '0) begin
            state_nxt = ST_DRAIN1;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_idx  = idx_cnt_r[vsn_pkg::IDX_W-1:0];
        idx_cnt_nxt = idx_inc;
        if (idx_inc == status.len) begin
          state_nxt = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        state_nxt = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_nxt = ST_SQINIT;
      end
      ST_SQINIT: begin
        cmd.sqrt_init = 1'b1;
        step_cnt_nxt  = '0;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_cnt_nxt  = vsn_pkg::STEP_W'(step_cnt_r + 1'b1);
        if (step_cnt_r == STEP_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_cnt_r  <= '0;
      step_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      idx_cnt_r  <= idx_cnt_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[hdl/vsn_datapath.sv]
// Datapath of the vector store: length register, coordinate RAM with valid
// bits, square-and-accumulate pipe, maximum tracker and a bit-serial square
// root. Uses vsn_pkg and vsn_ram.
`timescale 1ns / 1ps

module vsn_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vsn_pkg::dp_cmd_t            cmd,
  output vsn_pkg::dp_status_t         status,
  input  vsn_pkg::in_req_t            in_req,
  input  logic                        cfg_wr,
  input  logic [vsn_pkg::CFG_W-1:0]   cfg_data,
  output vsn_pkg::out_res_t           out_res
);

  logic [vsn_pkg::CFG_W-1:0]         cfg_len_r;
  logic [vsn_pkg::LEN_W-1:0]         len_eff;
  logic                              wr_ok;
  logic                              ram_we;
  logic [vsn_pkg::IDX_W-1:0]         ram_raddr;
  logic [vsn_pkg::VAL_W-1:0]         ram_rdata;
  logic [vsn_pkg::MAX_LENGTH-1:0]    vld_r;
  logic                              vld_rd_r;

  logic [vsn_pkg::IN_IDX_W-1:0]      ridx_r;
  logic                              ign_r;
  logic signed [vsn_pkg::VAL_W-1:0]  rval_r;
  logic [vsn_pkg::MAG_W-1:0]         max_r;
  logic [vsn_pkg::SUM_W-1:0]         acc_r;

  logic                              p1_v_r;
  logic [vsn_pkg::IDX_W-1:0]         p1_idx_r;
  logic                              p2_v_r;
  logic [vsn_pkg::SQ_W-1:0]          sq_r;
  logic [vsn_pkg::VAL_W-1:0]         entry;
  logic [vsn_pkg::MAG_W-1:0]         mag;

  logic [vsn_pkg::RAD_W-1:0]         rad_r;
  logic [vsn_pkg::REM_W-1:0]         rem_r;
  logic [vsn_pkg::ROOT_W-1:0]        root_r;
  logic [vsn_pkg::REM_W-1:0]         rem_sh;
  logic [vsn_pkg::REM_W-1:0]         trial;

  assign len_eff = (vsn_pkg::CMP_W'(cfg_len_r) > vsn_pkg::CMP_W'(vsn_pkg::MAX_LENGTH)) ?
                   vsn_pkg::LEN_W'(vsn_pkg::MAX_LENGTH) : vsn_pkg::LEN_W'(cfg_len_r);
  assign status.len = len_eff;

  assign wr_ok  = vsn_pkg::CMP_W'(in_req.write_index) < vsn_pkg::CMP_W'(len_eff);
  assign ram_we = cmd.load && in_req.write_enable && wr_ok;
  assign ram_raddr = cmd.rd_idx;

  vsn_ram #(
    .WIDTH (vsn_pkg::VAL_W),
    .DEPTH (vsn_pkg::MAX_LENGTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_req.write_index[vsn_pkg::IDX_W-1:0]),
    .wr_data (in_req.write_value),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign entry = vld_rd_r ? ram_rdata : '0;
  assign mag   = entry[vsn_pkg::VAL_W-1] ? vsn_pkg::MAG_W'(~entry + 1'b1)
                                          : vsn_pkg::MAG_W'(entry);

  assign rem_sh = {rem_r[vsn_pkg::REM_W-3:0], rad_r[vsn_pkg::RAD_W-1 -: 2]};
  assign trial  = vsn_pkg::REM_W'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= vsn_pkg::LEN_RESET;
      vld_r     <= '0;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cfg_len_r <= cfg_data;
      end
      if (ram_we) begin
        vld_r[in_req.write_index[vsn_pkg::IDX_W-1:0]] <= 1'b1;
      end
      p1_v_r <= cmd.rd_en;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    vld_rd_r <= vld_r[ram_raddr];
    p1_idx_r <= cmd.rd_idx;
    sq_r     <= mag * mag;

    if (cmd.load) begin
      ridx_r <= in_req.read_index;
      ign_r  <= in_req.write_enable && !wr_ok;
      rval_r <= '0;
      max_r  <= '0;
      acc_r  <= '0;
    end else begin
      if (p1_v_r) begin
        if (mag > max_r) begin
          max_r <= mag;
        end
        if (vsn_pkg::CMP_W'(p1_idx_r) == vsn_pkg::CMP_W'(ridx_r)) begin
          rval_r <= entry;
        end
      end
      if (p2_v_r) begin
        acc_r <= acc_r + vsn_pkg::SUM_W'(sq_r);
      end
    end

    if (cmd.sqrt_init) begin
      rad_r  <= vsn_pkg::RAD_W'(acc_r);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[vsn_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[vsn_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_res.read_value        = rval_r;
  assign out_res.euclid_norm       = root_r[vsn_pkg::NORM_W-1:0];
  assign out_res.largest_magnitude = max_r;
  assign out_res.write_ignored     = ign_r;

endmodule

[hdl/vector_store_with_norms_unit.sv]
// Top level of the vector store with Euclidean and maximum norms.
// Joins vsn_ctrl and vsn_datapath; uses vsn_pkg and assert_macros.svh.
//
// A request is taken when start is high and busy is low; it may write one
// coordinate and reads one back, then the block walks the first
// vector_length entries through the single read port of the coordinate RAM
// and takes the square root one result bit per cycle. The result appears on
// out_res for exactly one cycle with out_valid high, and busy falls in the
// cycle after that, so a new request is taken only after the last result
// has been shown. The receiver cannot stall and must take the result in
// the cycle it is shown. The length register may be written through the
// cfg channel whenever the block is idle; cfg_ready is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vector_store_with_norms_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  vsn_pkg::in_req_t           in_req,
  output logic                       out_valid,
  output vsn_pkg::out_res_t          out_res,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vsn_pkg::CFG_W-1:0]  cfg_data
);

  vsn_pkg::dp_cmd_t    cmd;
  vsn_pkg::dp_status_t status;
  logic                norm_covers_max;

  assign cfg_ready = 1'b1;
  assign out_valid = cmd.done;

  vsn_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  vsn_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_req   (in_req),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_res  (out_res)
  );

  assign norm_covers_max =
    (out_res.euclid_norm >= vsn_pkg::NORM_W'(out_res.largest_magnitude));

  `VSN_ASSERT(a_strobe_single, clk, rst_n, out_valid |=> !out_valid, "result strobe too long")
  `VSN_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "not busy after a request")
  `VSN_ASSERT(a_norm_ge_max, clk, rst_n, out_valid |-> norm_covers_max, "norm below largest magnitude")
  `VSN_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !busy, "block busy after reset")

endmodule
